>>> hw/rtl/bal_pkg.sv
// Shared types and constants for the bounded array list core.
package bal_pkg;

  localparam int MAX_DEPTH  = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(MAX_DEPTH);
  localparam int CNT_W      = 5;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_POP    = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_code_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_APPEND = 2'd2,
    OP_ERASE  = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [CNT_W-1:0]      position;
    logic [DATA_WIDTH-1:0] value;
  } bal_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [DATA_WIDTH-1:0] read_data;
    logic [CNT_W-1:0]      count;
    logic                  is_empty;
    logic [DATA_WIDTH-1:0] first_element;
    logic [DATA_WIDTH-1:0] last_element;
  } bal_result_t;

  // Broadcast to every cell of the row
  typedef struct packed {
    cell_op_t              op;
    logic [CNT_W-1:0]      pos;
    logic [CNT_W-1:0]      count;
    logic [DATA_WIDTH-1:0] value;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/bounded_array_list_core.sv
// Top level of the bounded array list: command decode, count, and the row of cells.
//
//   channel    signals                       direction  handshake
//   command    start, busy, command          in         taken when start && !busy
//   result     done, result                  out        registered, no stall
//   capacity   capacity_we, capacity_data    in         written when capacity_we
//
// One command per cycle; busy stays low. The row of cells updates at the edge that
// takes the command and the result is shown for the following cycle only.
// rst clears the count, the capacity (to sixteen) and done; cell contents are left as they are.
// The receiver cannot stall: a result not taken in its cycle is gone.
module bounded_array_list_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  bal_pkg::bal_cmd_t      command,
  output logic                   done,
  output bal_pkg::bal_result_t   result,
  input  logic                   capacity_we,
  input  logic [bal_pkg::CNT_W-1:0] capacity_data
);

  localparam int DEPTH = bal_pkg::MAX_DEPTH;
  localparam int IW    = bal_pkg::IDX_W;
  localparam int CW    = bal_pkg::CNT_W;
  localparam int DW    = bal_pkg::DATA_WIDTH;

  logic [CW-1:0]         capacity_limit;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         cap_eff;
  logic [bal_pkg::STATUS_W-1:0] status;
  logic [bal_pkg::STATUS_W-1:0] status_next;
  logic [DW-1:0]         read_data;
  logic [DW-1:0]         read_data_next;
  logic                  accept;
  logic                  full;
  logic [CW-1:0]         last_idx;
  bal_pkg::cell_ctrl_t   ctrl;
  logic [DW-1:0]         cell_q [DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign cap_eff = (capacity_limit > CW'(DEPTH)) ? CW'(DEPTH) : capacity_limit;
  assign full    = (count >= cap_eff) || (count >= CW'(DEPTH));

  always_comb begin
    status_next    = bal_pkg::ST_OK;
    read_data_next = '0;
    count_next     = count;
    ctrl.op        = bal_pkg::OP_HOLD;
    ctrl.pos       = command.position;
    ctrl.count     = count;
    ctrl.value     = command.value;
    if (accept) begin
      unique case (command.cmd)
        bal_pkg::CMD_READ: begin
          if (command.position >= count || command.position >= CW'(DEPTH))
            status_next = bal_pkg::ST_RANGE;
          else
            read_data_next = cell_q[command.position[IW-1:0]];
        end
        bal_pkg::CMD_INSERT: begin
          if (command.position > count) status_next = bal_pkg::ST_RANGE;
          else if (full) status_next = bal_pkg::ST_FULL;
          else begin
            ctrl.op    = bal_pkg::OP_INSERT;
            count_next = count + CW'(1);
          end
        end
        bal_pkg::CMD_APPEND: begin
          if (full) status_next = bal_pkg::ST_FULL;
          else begin
            ctrl.op    = bal_pkg::OP_APPEND;
            count_next = count + CW'(1);
          end
        end
        bal_pkg::CMD_ERASE: begin
          if (count == '0) status_next = bal_pkg::ST_EMPTY;
          else if (command.position >= count) status_next = bal_pkg::ST_RANGE;
          else begin
            ctrl.op    = bal_pkg::OP_ERASE;
            count_next = count - CW'(1);
          end
        end
        bal_pkg::CMD_POP: begin
          if (count == '0) status_next = bal_pkg::ST_EMPTY;
          else count_next = count - CW'(1);
        end
        bal_pkg::CMD_CLEAR: begin
          count_next = '0;
        end
        default: begin
          // unused codes: report ok, change nothing
        end
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_row
      logic [DW-1:0] below_w;
      logic [DW-1:0] above_w;
      if (g == 0) begin : g_lo
        assign below_w = '0;
      end else begin : g_lo
        assign below_w = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_hi
        assign above_w = '0;
      end else begin : g_hi
        assign above_w = cell_q[g+1];
      end
      bal_cell u_cell (
        .clk   (clk),
        .slot  (IW'(g)),
        .ctrl  (ctrl),
        .below (below_w),
        .above (above_w),
        .word  (cell_q[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CW'(16);
      count          <= '0;
      done           <= 1'b0;
    end else begin
      if (capacity_we) capacity_limit <= capacity_data;
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    status    <= status_next;
    read_data <= read_data_next;
  end

  assign last_idx = count - CW'(1);

  always_comb begin
    result.status    = status;
    result.read_data = read_data;
    result.count     = count;
    result.is_empty  = (count == '0);
    if (count == '0) begin
      result.first_element = '0;
      result.last_element  = '0;
    end else begin
      result.first_element = cell_q[0];
      result.last_element  = cell_q[last_idx[IW-1:0]];
    end
  end

endmodule

>>> hw/rtl/bal_cell.sv
// One storage cell of the list row: holds a word, loads or takes a neighbor's word.
module bal_cell (
  input  logic                              clk,
  input  logic [bal_pkg::IDX_W-1:0]         slot,
  input  bal_pkg::cell_ctrl_t               ctrl,
  input  logic [bal_pkg::DATA_WIDTH-1:0]    below,
  input  logic [bal_pkg::DATA_WIDTH-1:0]    above,
  output logic [bal_pkg::DATA_WIDTH-1:0]    word
);

  logic [bal_pkg::CNT_W-1:0]      slot_ext;
  logic [bal_pkg::DATA_WIDTH-1:0] word_next;

  assign slot_ext = bal_pkg::CNT_W'(slot);

  always_comb begin
    word_next = word;
    unique case (ctrl.op)
      bal_pkg::OP_INSERT: begin
        // cells above the gap move up one place
        if (slot_ext == ctrl.pos) word_next = ctrl.value;
        else if (slot_ext > ctrl.pos) word_next = below;
      end
      bal_pkg::OP_APPEND: begin
        if (slot_ext == ctrl.count) word_next = ctrl.value;
      end
      bal_pkg::OP_ERASE: begin
        // close the gap: take the upper neighbor
        if (slot_ext >= ctrl.pos) word_next = above;
      end
      bal_pkg::OP_HOLD: begin
        word_next = word;
      end
      default: word_next = word;
    endcase
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule
